@@ sv/lbr_pkg.sv @@
`default_nettype none

package lbr_pkg;

    // String capacity and derived widths
    localparam int MAX_LEN = 4096;
    localparam int POS_W   = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int LEN_W   = 13;
    localparam int KIND_W  = 2;

    // Bracket kinds held in a stack entry
    localparam logic [KIND_W-1:0] KIND_OTHER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd3;

    // Character codes
    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;

    // One unmatched stack entry
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    function automatic logic [KIND_W-1:0] open_kind(input logic [7:0] ch);
        logic [KIND_W-1:0] k;
        unique case (ch)
            CH_OPEN_ROUND:  k = KIND_ROUND;
            CH_OPEN_SQUARE: k = KIND_SQUARE;
            CH_OPEN_CURLY:  k = KIND_CURLY;
            default:        k = KIND_OTHER;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] close_kind(input logic [7:0] ch);
        logic [KIND_W-1:0] k;
        unique case (ch)
            CH_CLOSE_ROUND:  k = KIND_ROUND;
            CH_CLOSE_SQUARE: k = KIND_SQUARE;
            CH_CLOSE_CURLY:  k = KIND_CURLY;
            default:         k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

@@ sv/lbr_ram.sv @@
`default_nettype none

module lbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/longest_balanced_bracket_run.sv @@
`default_nettype none

// Channel  Direction  Handshake          Payload
// request  in         i_valid / o_stall  i_ch[7:0], i_last
// result   out        o_valid / i_stall  o_longest[12:0], o_overflow
//
// One character per cycle while o_stall is low; the result shows up in the cycle after the request
// with i_last is taken. The top stack entry sits in a register and the entry
// below it is read from the stack RAM every cycle, so pops and pushes run
// back to back. Synchronous reset clears all control state; the stack RAM
// needs no clearing. o_stall is high only while a result waits and i_stall
// holds it.

module longest_balanced_bracket_run
    import lbr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [7:0]       i_ch,
    input  wire logic             i_last,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic      [LEN_W-1:0] o_longest,
    output logic                  o_overflow
);

    logic [CNT_W-1:0] r_depth, n_depth;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [LEN_W-1:0] r_best, n_best;
    logic             r_ovf, n_ovf;
    t_entry           r_top, n_top;
    logic             r_out_valid;
    logic [LEN_W-1:0] r_out_longest;
    logic             r_out_ovf;

    logic             accept;
    logic             in_range;
    logic [KIND_W-1:0] ok, ck;
    logic             match;
    t_entry           below;
    t_entry           push_entry;
    logic             mem_we;
    logic [CNT_W-1:0] rd_idx;
    logic [LEN_W-1:0] run;
    logic [LEN_W-1:0] best_now;
    logic             ovf_now;

    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    // Character decode and match against the cached top
    assign in_range   = (r_pos != CNT_W'(MAX_LEN));
    assign ok         = open_kind(i_ch);
    assign ck         = close_kind(i_ch);
    assign match      = (ck != KIND_OTHER) && (r_depth != '0) && (r_top.kind == ck);
    assign push_entry = '{kind: ok, pos: r_pos[POS_W-1:0]};

    // Run length after a pop: to the new top, or from the start of the string
    always_comb begin
        if (r_depth == CNT_W'(1)) begin
            run = LEN_W'(r_pos) + LEN_W'(1);
        end else begin
            run = LEN_W'(r_pos[POS_W-1:0]) - LEN_W'(below.pos);
        end
    end

    // Next state for the stack, position and best run
    always_comb begin
        n_depth  = r_depth;
        n_pos    = r_pos;
        n_top    = r_top;
        best_now = r_best;
        ovf_now  = r_ovf;
        mem_we   = 1'b0;
        if (accept) begin
            if (in_range) begin
                n_pos = r_pos + CNT_W'(1);
                if (match) begin
                    n_depth = r_depth - CNT_W'(1);
                    n_top   = below;
                    if (run > r_best) begin
                        best_now = run;
                    end
                end else begin
                    n_depth = r_depth + CNT_W'(1);
                    n_top   = push_entry;
                    mem_we  = 1'b1;
                end
            end else begin
                ovf_now = 1'b1;
            end
        end
        n_best = best_now;
        n_ovf  = ovf_now;
        // End of string: back to empty
        if (accept && i_last) begin
            n_depth = '0;
            n_pos   = '0;
            n_best  = '0;
            n_ovf   = 1'b0;
        end
    end

    // Keep the entry under the next top on the RAM read port
    assign rd_idx = n_depth - CNT_W'(2);

    lbr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_LEN)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_depth[POS_W-1:0]),
        .i_wdata (push_entry),
        .i_raddr (rd_idx[POS_W-1:0]),
        .o_rdata (below)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_pos       <= '0;
            r_best      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_depth <= n_depth;
            r_pos   <= n_pos;
            r_best  <= n_best;
            r_ovf   <= n_ovf;
            if (accept && i_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Cached top and result payload
    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (accept && i_last) begin
            r_out_longest <= best_now;
            r_out_ovf     <= ovf_now;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_longest  = r_out_longest;
    assign o_overflow = r_out_ovf;

endmodule

`default_nettype wire

@@ sv/lbr_checker.sv @@
`default_nettype none

module lbr_checker
    import lbr_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_valid,
    input wire logic             o_stall,
    input wire logic             i_last,
    input wire logic             o_valid,
    input wire logic             i_stall,
    input wire logic [LEN_W-1:0] o_longest,
    input wire logic             o_overflow
);

    logic req_last;
    assign req_last = i_valid & ~o_stall & i_last;

    // A held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_longest) && $stable(o_overflow))
        else $error("result changed while stalled");

    // Reset empties the result stage
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Every accepted last character yields a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_last |=> o_valid)
        else $error("no result after last character");

    // A result never appears without a last character
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(req_last))
        else $error("result without last character");

    // Longest run cannot exceed the string capacity
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_longest <= LEN_W'(MAX_LEN)))
        else $error("longest run out of range");

endmodule

bind longest_balanced_bracket_run lbr_checker u_lbr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .i_last     (i_last),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_longest  (o_longest),
    .o_overflow (o_overflow)
);

`default_nettype wire

@@ sim/longest_balanced_bracket_run_test.sv @@
`default_nettype none

module longest_balanced_bracket_run_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lbr_pkg::*;

    localparam int LONGEST_CAP = (1 << LEN_W) - 1;

    typedef struct packed {
        logic [LEN_W-1:0] longest;
        logic             overflow;
    } t_answer;

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [7:0]       i_ch    = 8'h00;
    logic             i_last  = 1'b0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [LEN_W-1:0] o_longest;
    logic             o_overflow;

    longest_balanced_bracket_run dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_ch       (i_ch),
        .i_last     (i_last),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_longest  (o_longest),
        .o_overflow (o_overflow)
    );

    // Quiet phases run with no sender gaps and no result stalls
    bit quiet = 1'b0;

    int mismatches    = 0;
    int strings_done  = 0;
    int chars_sent    = 0;
    int overflow_seen = 0;
    int stall_hold    = 0;

    // Shadow of the block: unmatched openers, current string progress
    logic [KIND_W-1:0] open_kinds [MAX_LEN];
    logic [POS_W-1:0]  open_pos   [MAX_LEN];
    int unsigned       depth      = 0;
    int unsigned       taken      = 0;
    int unsigned       best_run   = 0;
    bit                too_long   = 1'b0;
    t_answer           answers [$];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH @%0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Update the shadow stack for one request; queue the answer on the last byte
    function automatic void track_char(input logic [7:0] c, input logic fin);
        logic [KIND_W-1:0] opener;
        logic [KIND_W-1:0] closer;
        int unsigned       run;
        t_answer           ans;
        opener = KIND_OTHER;
        closer = KIND_OTHER;
        case (c)
            CH_OPEN_ROUND:   opener = KIND_ROUND;
            CH_OPEN_SQUARE:  opener = KIND_SQUARE;
            CH_OPEN_CURLY:   opener = KIND_CURLY;
            CH_CLOSE_ROUND:  closer = KIND_ROUND;
            CH_CLOSE_SQUARE: closer = KIND_SQUARE;
            CH_CLOSE_CURLY:  closer = KIND_CURLY;
            default: ;
        endcase
        if (taken >= MAX_LEN) begin
            too_long = 1'b1;
        end else begin
            if (closer != KIND_OTHER && depth > 0 && open_kinds[depth-1] == closer) begin
                depth--;
                run = (depth == 0) ? taken + 1 : taken - open_pos[depth-1];
                if (run > best_run)
                    best_run = run;
            end else if (depth < MAX_LEN) begin
                open_kinds[depth] = opener;
                open_pos[depth]   = taken[POS_W-1:0];
                depth++;
            end
            taken++;
        end
        if (fin) begin
            ans.longest  = (best_run > LONGEST_CAP) ? LEN_W'(LONGEST_CAP) : LEN_W'(best_run);
            ans.overflow = too_long;
            answers.push_back(ans);
            depth    = 0;
            taken    = 0;
            best_run = 0;
            too_long = 1'b0;
        end
    endfunction

    // Track accepted requests and check each accepted result
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                track_char(i_ch, i_last);
            if (o_valid && !i_stall) begin
                if (answers.size() == 0) begin
                    report_mismatch("result with no string pending", o_longest, -1);
                end else begin
                    want = answers.pop_front();
                    if (o_longest !== want.longest)
                        report_mismatch("longest", o_longest, want.longest);
                    if (o_overflow !== want.overflow)
                        report_mismatch("overflow", o_overflow, want.overflow);
                    strings_done++;
                    if (want.overflow)
                        overflow_seen++;
                end
            end
        end
    end

    // Result-side back-pressure: mostly free, short stalls, a few long ones
    always @(posedge i_clk) begin
        int r;
        if (!i_rst_n || quiet) begin
            i_stall    <= 1'b0;
            stall_hold = 0;
        end else if (stall_hold > 0) begin
            stall_hold--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                i_stall    <= 1'b0;
                stall_hold = $urandom_range(0, 4);
            end else if (r < 95) begin
                i_stall    <= 1'b1;
                stall_hold = $urandom_range(0, 2);
            end else begin
                i_stall    <= 1'b1;
                stall_hold = $urandom_range(10, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Send one request; valid stays high into the next request when no gap
    task automatic send_char(input logic [7:0] c, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch    <= c;
        i_last  <= fin;
        do @(posedge i_clk); while (o_stall);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int n = 0; n < s.len(); n++)
            send_char(s[n], n == s.len() - 1);
    endtask

    function automatic logic [7:0] opener_char(input logic [KIND_W-1:0] k);
        case (k)
            KIND_ROUND:  return CH_OPEN_ROUND;
            KIND_SQUARE: return CH_OPEN_SQUARE;
            default:     return CH_OPEN_CURLY;
        endcase
    endfunction

    function automatic logic [7:0] closer_char(input logic [KIND_W-1:0] k);
        case (k)
            KIND_ROUND:  return CH_CLOSE_ROUND;
            KIND_SQUARE: return CH_CLOSE_SQUARE;
            default:     return CH_CLOSE_CURLY;
        endcase
    endfunction

    // Mostly nested brackets that close properly, some stray closers and noise
    task automatic send_random_string(input int len);
        logic [KIND_W-1:0] kinds [$];
        logic [KIND_W-1:0] k;
        logic [7:0]        c;
        int                r;
        for (int n = 0; n < len; n++) begin
            r = $urandom_range(0, 99);
            if (r < 38) begin
                k = KIND_W'($urandom_range(1, 3));
                kinds.push_back(k);
                c = opener_char(k);
            end else if (r < 80 && kinds.size() > 0) begin
                c = closer_char(kinds.pop_back());
            end else if (r < 90) begin
                c = closer_char(KIND_W'($urandom_range(1, 3)));
            end else begin
                c = 8'($urandom_range(0, 255));
            end
            send_char(c, n == len - 1);
        end
    endtask

    // Short strings: each bracket kind, mismatches, stray closers, odd bytes
    task automatic test_short_strings();
        send_text(")");
        send_text("()");
        send_text("([{}])");
        send_text("(]");
        send_text("{}[]()");
        send_text("(()");
        // zero byte and all-ones byte behave as ordinary non-bracket bytes
        send_char(CH_OPEN_ROUND, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(CH_CLOSE_ROUND, 1'b1);
        send_char(CH_OPEN_SQUARE, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(CH_CLOSE_SQUARE, 1'b1);
    endtask

    task automatic test_random_strings(input int budget, input bit calm);
        int start;
        int r;
        int len;
        quiet <= calm;
        start = chars_sent;
        while (chars_sent - start < budget) begin
            r = $urandom_range(0, 99);
            if (r < 85)
                len = $urandom_range(1, 40);
            else if (r < 98)
                len = $urandom_range(41, 300);
            else
                len = $urandom_range(301, 1200);
            // keep the total close to the budget
            if (len > budget - (chars_sent - start))
                len = budget - (chars_sent - start);
            send_random_string(len);
        end
        quiet <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_short_strings();
        test_random_strings(300, 1'b1);
        test_random_strings(1574, 1'b0);

        // drain outstanding answers, then watch for stray results
        i_valid <= 1'b0;
        while (answers.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Checked %0d strings (%0d over capacity) from %0d bytes sent.",
                 strings_done, overflow_seen, chars_sent);
        $display("Covered all bracket kinds, stray closers, noise bytes and long strings.");
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
